[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/cau_pkg.sv]
// Shared types, codes and saturation helpers of the complex arithmetic unit.
package cau_pkg;

   localparam int unsigned DATA_W = 16;
   localparam int unsigned QBITS  = 17;

   typedef enum logic [2:0] {
      ACT_ADD  = 3'd0,
      ACT_SUB  = 3'd1,
      ACT_MUL  = 3'd2,
      ACT_DIV  = 3'd3,
      ACT_CONJ = 3'd4,
      ACT_EQ   = 3'd5
   } action_type;

   // Control and finished result fields that travel with a transaction.
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg_re;
      logic              neg_im;
      logic              qovf_re;
      logic              qovf_im;
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              eq;
      logic              dz;
      logic              ov;
   } ctrl_type;

   // Saturate a sign and magnitude to 16 signed bits; returns {overflow, value}.
   function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [QBITS-1:0] mag);
      logic [QBITS-1:0] nm;
      nm = ~mag + 17'd1;
      if (!neg) begin
         if (mag > 17'd32767) return {1'b1, 16'h7FFF};
         return {1'b0, mag[DATA_W-1:0]};
      end
      if (mag > 17'd32768) return {1'b1, 16'h8000};
      return {1'b0, nm[DATA_W-1:0]};
   endfunction

   // Saturate a 17-bit signed value to 16 bits; returns {overflow, value}.
   function automatic logic [DATA_W:0] sat17(input logic signed [QBITS-1:0] v);
      if (v > 17'sd32767) return {1'b1, 16'h7FFF};
      if (v < -17'sd32768) return {1'b1, 16'h8000};
      return {1'b0, v[DATA_W-1:0]};
   endfunction

endpackage

[rtl/cau_if.sv]
// Request and response channel interfaces.
interface cau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic signed [15:0] a_real;
   logic signed [15:0] a_imag;
   logic signed [15:0] b_real;
   logic signed [15:0] b_imag;
   modport source(output valid, action, a_real, a_imag, b_real, b_imag, input ready);
   modport sink(input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] result_real;
   logic signed [15:0] result_imag;
   logic        is_equal;
   logic        divide_by_zero;
   logic        overflow;
   modport source(output valid, result_real, result_imag, is_equal, divide_by_zero,
                  overflow, input ready);
   modport sink(input valid, result_real, result_imag, is_equal, divide_by_zero,
                overflow, output ready);
endinterface

[rtl/cau_div_cell.sv]
// One restoring-division cell: one quotient bit for real and imaginary parts.
module cau_div_cell #(
   parameter int unsigned DW   = 33,
   parameter int unsigned STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  cau_pkg::ctrl_type        ctrl_i,
   input  logic [DW-1:0]            d_i,
   input  logic [DW-1:0]            rem_re_i,
   input  logic [DW-1:0]            rem_im_i,
   input  logic [cau_pkg::QBITS-1:0] nlo_re_i,
   input  logic [cau_pkg::QBITS-1:0] nlo_im_i,
   input  logic [cau_pkg::QBITS-1:0] q_re_i,
   input  logic [cau_pkg::QBITS-1:0] q_im_i,
   output cau_pkg::ctrl_type        ctrl_o,
   output logic [DW-1:0]            d_o,
   output logic [DW-1:0]            rem_re_o,
   output logic [DW-1:0]            rem_im_o,
   output logic [cau_pkg::QBITS-1:0] nlo_re_o,
   output logic [cau_pkg::QBITS-1:0] nlo_im_o,
   output logic [cau_pkg::QBITS-1:0] q_re_o,
   output logic [cau_pkg::QBITS-1:0] q_im_o
);

   localparam int unsigned BIT = cau_pkg::QBITS - 1 - STEP;

   logic [DW:0]   t_re, t_im, dx;
   logic          ge_re, ge_im;
   logic [DW:0]   diff_re, diff_im;

   cau_pkg::ctrl_type             ctrl_ff;
   logic [DW-1:0]                 d_ff, rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [cau_pkg::QBITS-1:0]     nlo_re_ff, nlo_im_ff, q_re_ff, q_im_ff, q_re_in, q_im_in;

   always_comb begin
      dx        = {1'b0, d_i};
      t_re      = {rem_re_i, nlo_re_i[BIT]};
      t_im      = {rem_im_i, nlo_im_i[BIT]};
      ge_re     = t_re >= dx;
      ge_im     = t_im >= dx;
      diff_re   = t_re - dx;
      diff_im   = t_im - dx;
      rem_re_in = ge_re ? diff_re[DW-1:0] : t_re[DW-1:0];
      rem_im_in = ge_im ? diff_im[DW-1:0] : t_im[DW-1:0];
      q_re_in   = {q_re_i[cau_pkg::QBITS-2:0], ge_re};
      q_im_in   = {q_im_i[cau_pkg::QBITS-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (en) begin
         ctrl_ff.is_div  <= ctrl_i.is_div;
         ctrl_ff.neg_re  <= ctrl_i.neg_re;
         ctrl_ff.neg_im  <= ctrl_i.neg_im;
         ctrl_ff.qovf_re <= ctrl_i.qovf_re;
         ctrl_ff.qovf_im <= ctrl_i.qovf_im;
         ctrl_ff.res_re  <= ctrl_i.res_re;
         ctrl_ff.res_im  <= ctrl_i.res_im;
         ctrl_ff.eq      <= ctrl_i.eq;
         ctrl_ff.dz      <= ctrl_i.dz;
         ctrl_ff.ov      <= ctrl_i.ov;
         d_ff      <= d_i;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         nlo_re_ff <= nlo_re_i;
         nlo_im_ff <= nlo_im_i;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
      end
   end

   assign ctrl_o   = ctrl_ff;
   assign d_o      = d_ff;
   assign rem_re_o = rem_re_ff;
   assign rem_im_o = rem_im_ff;
   assign nlo_re_o = nlo_re_ff;
   assign nlo_im_o = nlo_im_ff;
   assign q_re_o   = q_re_ff;
   assign q_im_o   = q_im_ff;

endmodule

[rtl/complex_arithmetic_unit_top.sv]
// Top level of the complex arithmetic unit: front pipeline, division cell chain, output register.
//
// Usage:
//   req_ch carries one transaction per operand pair: action, a_real, a_imag, b_real,
//   b_imag (signed fixed point, FRAC_BITS fraction bits). rsp_ch returns exactly one
//   transaction per request, in order: result_real, result_imag, is_equal,
//   divide_by_zero, overflow.
//   Every action passes through three front stages (products, sums, rounding/divide
//   setup), 17 division cells (one quotient bit each) and one output register.
//   Throughput is one transaction per cycle while the receiver takes results; the
//   cell chain keeps pace, since each cell works on a different transaction.
//   All stages advance together. When the output register holds a result that the
//   receiver does not take, every stage holds and req_ch.ready drops; bubbles in the
//   pipe do not fill while held. When it is empty or being taken, the pipe advances.
//   Reset (synchronous, active high) clears every valid bit; nothing is in flight
//   afterward and req_ch.ready is high in the next cycle.
module complex_arithmetic_unit_top #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);

   localparam int unsigned QB   = cau_pkg::QBITS;
   localparam int unsigned DW   = 33;                 // twice the divisor magnitude
   localparam int unsigned NW   = 34 + FRAC_BITS;     // rounded, scaled dividend
   localparam int unsigned HW   = NW - QB;            // dividend bits above the quotient
   localparam int unsigned RW   = 34;                 // rounded product magnitude
   localparam logic [RW-1:0] HALF = (FRAC_BITS == 0) ? '0 : RW'(1) << (FRAC_BITS - 1);

   logic en;

   // ---------------- Stage A: products and the simple actions ----------------
   cau_pkg::ctrl_type  a_ctrl_in, a_ctrl_ff;
   logic [2:0]         a_act_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [16:0] s_re, s_im;
   logic [16:0]        sat_re, sat_im;

   // Hold the whole pipe while a finished result waits at the output.
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      a_ctrl_in       = '0;
      a_ctrl_in.valid = req_ch.valid;
      s_re            = '0;
      s_im            = '0;
      unique case (req_ch.action)
         cau_pkg::ACT_ADD: begin
            s_re = {req_ch.a_real[15], req_ch.a_real} + {req_ch.b_real[15], req_ch.b_real};
            s_im = {req_ch.a_imag[15], req_ch.a_imag} + {req_ch.b_imag[15], req_ch.b_imag};
         end
         cau_pkg::ACT_SUB: begin
            s_re = {req_ch.a_real[15], req_ch.a_real} - {req_ch.b_real[15], req_ch.b_real};
            s_im = {req_ch.a_imag[15], req_ch.a_imag} - {req_ch.b_imag[15], req_ch.b_imag};
         end
         cau_pkg::ACT_CONJ: begin
            s_re = {req_ch.a_real[15], req_ch.a_real};
            s_im = -{req_ch.a_imag[15], req_ch.a_imag};
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      sat_re           = cau_pkg::sat17(s_re);
      sat_im           = cau_pkg::sat17(s_im);
      a_ctrl_in.res_re = sat_re[15:0];
      a_ctrl_in.res_im = sat_im[15:0];
      a_ctrl_in.ov     = sat_re[16] | sat_im[16];
      a_ctrl_in.eq     = (req_ch.action == cau_pkg::ACT_EQ) &&
                         (req_ch.a_real == req_ch.b_real) &&
                         (req_ch.a_imag == req_ch.b_imag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         a_ctrl_ff.valid <= a_ctrl_in.valid;
      end
      if (en) begin
         a_ctrl_ff.is_div  <= a_ctrl_in.is_div;
         a_ctrl_ff.neg_re  <= a_ctrl_in.neg_re;
         a_ctrl_ff.neg_im  <= a_ctrl_in.neg_im;
         a_ctrl_ff.qovf_re <= a_ctrl_in.qovf_re;
         a_ctrl_ff.qovf_im <= a_ctrl_in.qovf_im;
         a_ctrl_ff.res_re  <= a_ctrl_in.res_re;
         a_ctrl_ff.res_im  <= a_ctrl_in.res_im;
         a_ctrl_ff.eq      <= a_ctrl_in.eq;
         a_ctrl_ff.dz      <= a_ctrl_in.dz;
         a_ctrl_ff.ov      <= a_ctrl_in.ov;
         a_act_ff <= req_ch.action;
         p_rr_ff  <= req_ch.a_real * req_ch.b_real;
         p_ii_ff  <= req_ch.a_imag * req_ch.b_imag;
         p_ri_ff  <= req_ch.a_real * req_ch.b_imag;
         p_ir_ff  <= req_ch.a_imag * req_ch.b_real;
         sq_r_ff  <= req_ch.b_real * req_ch.b_real;
         sq_i_ff  <= req_ch.b_imag * req_ch.b_imag;
      end
   end

   // ---------------- Stage B: sums of products ----------------
   cau_pkg::ctrl_type  b_ctrl_ff;
   logic [2:0]         b_act_ff;
   logic signed [32:0] mre_ff, mim_ff, dre_ff, dim_ff;
   logic [31:0]        den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         b_ctrl_ff.valid <= a_ctrl_ff.valid;
      end
      if (en) begin
         b_ctrl_ff.is_div  <= a_ctrl_ff.is_div;
         b_ctrl_ff.neg_re  <= a_ctrl_ff.neg_re;
         b_ctrl_ff.neg_im  <= a_ctrl_ff.neg_im;
         b_ctrl_ff.qovf_re <= a_ctrl_ff.qovf_re;
         b_ctrl_ff.qovf_im <= a_ctrl_ff.qovf_im;
         b_ctrl_ff.res_re  <= a_ctrl_ff.res_re;
         b_ctrl_ff.res_im  <= a_ctrl_ff.res_im;
         b_ctrl_ff.eq      <= a_ctrl_ff.eq;
         b_ctrl_ff.dz      <= a_ctrl_ff.dz;
         b_ctrl_ff.ov      <= a_ctrl_ff.ov;
         b_act_ff <= a_act_ff;
         mre_ff   <= 33'(p_rr_ff) - 33'(p_ii_ff);
         mim_ff   <= 33'(p_ri_ff) + 33'(p_ir_ff);
         dre_ff   <= 33'(p_rr_ff) + 33'(p_ii_ff);
         dim_ff   <= 33'(p_ir_ff) - 33'(p_ri_ff);
         den_ff   <= 32'(sq_r_ff) + 32'(sq_i_ff);
      end
   end

   // ---------------- Stage C: product rounding and divide setup ----------------
   cau_pkg::ctrl_type c_ctrl_in, c_ctrl_ff;
   logic [32:0]       mag_mre, mag_mim, mag_dre, mag_dim;
   logic [RW-1:0]     r_re, r_im;
   logic [QB-1:0]     clip_re, clip_im;
   logic [16:0]       msat_re, msat_im;
   logic [NW-1:0]     n_re, n_im;
   logic [DW-1:0]     dd, hi_re, hi_im;
   logic              den_zero;
   logic [DW-1:0]     c_d_ff, c_rem_re_ff, c_rem_im_ff;
   logic [QB-1:0]     c_nlo_re_ff, c_nlo_im_ff;

   always_comb begin
      mag_mre  = mre_ff[32] ? 33'(-mre_ff) : 33'(mre_ff);
      mag_mim  = mim_ff[32] ? 33'(-mim_ff) : 33'(mim_ff);
      r_re     = (RW'(mag_mre) + HALF) >> FRAC_BITS;
      r_im     = (RW'(mag_mim) + HALF) >> FRAC_BITS;
      clip_re  = (r_re[RW-1:QB] != '0) ? '1 : r_re[QB-1:0];
      clip_im  = (r_im[RW-1:QB] != '0) ? '1 : r_im[QB-1:0];
      msat_re  = cau_pkg::sat_mag(mre_ff[32], clip_re);
      msat_im  = cau_pkg::sat_mag(mim_ff[32], clip_im);

      // Round to nearest: quotient of (2m + d) over 2d.
      mag_dre  = dre_ff[32] ? 33'(-dre_ff) : 33'(dre_ff);
      mag_dim  = dim_ff[32] ? 33'(-dim_ff) : 33'(dim_ff);
      n_re     = (NW'(mag_dre[31:0]) << (FRAC_BITS + 1)) + NW'(den_ff);
      n_im     = (NW'(mag_dim[31:0]) << (FRAC_BITS + 1)) + NW'(den_ff);
      dd       = {den_ff, 1'b0};
      hi_re    = DW'(n_re[NW-1:QB]);
      hi_im    = DW'(n_im[NW-1:QB]);
      den_zero = (den_ff == '0);

      c_ctrl_in = b_ctrl_ff;
      priority case (1'b1)
         b_act_ff == cau_pkg::ACT_MUL: begin
            c_ctrl_in.res_re = msat_re[15:0];
            c_ctrl_in.res_im = msat_im[15:0];
            c_ctrl_in.ov     = msat_re[16] | msat_im[16];
         end
         b_act_ff == cau_pkg::ACT_DIV: begin
            c_ctrl_in.res_re  = '0;
            c_ctrl_in.res_im  = '0;
            c_ctrl_in.ov      = 1'b0;
            c_ctrl_in.dz      = den_zero;
            c_ctrl_in.is_div  = !den_zero;
            c_ctrl_in.neg_re  = dre_ff[32];
            c_ctrl_in.neg_im  = dim_ff[32];
            c_ctrl_in.qovf_re = hi_re >= dd;
            c_ctrl_in.qovf_im = hi_im >= dd;
         end
         default: begin
            c_ctrl_in.is_div = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         c_ctrl_ff.valid <= c_ctrl_in.valid;
      end
      if (en) begin
         c_ctrl_ff.is_div  <= c_ctrl_in.is_div;
         c_ctrl_ff.neg_re  <= c_ctrl_in.neg_re;
         c_ctrl_ff.neg_im  <= c_ctrl_in.neg_im;
         c_ctrl_ff.qovf_re <= c_ctrl_in.qovf_re;
         c_ctrl_ff.qovf_im <= c_ctrl_in.qovf_im;
         c_ctrl_ff.res_re  <= c_ctrl_in.res_re;
         c_ctrl_ff.res_im  <= c_ctrl_in.res_im;
         c_ctrl_ff.eq      <= c_ctrl_in.eq;
         c_ctrl_ff.dz      <= c_ctrl_in.dz;
         c_ctrl_ff.ov      <= c_ctrl_in.ov;
         c_d_ff      <= dd;
         c_rem_re_ff <= hi_re;
         c_rem_im_ff <= hi_im;
         c_nlo_re_ff <= n_re[QB-1:0];
         c_nlo_im_ff <= n_im[QB-1:0];
      end
   end

   // ---------------- Division cell chain ----------------
   cau_pkg::ctrl_type ch_ctrl [QB+1];
   logic [DW-1:0]     ch_d    [QB+1];
   logic [DW-1:0]     ch_rre  [QB+1];
   logic [DW-1:0]     ch_rim  [QB+1];
   logic [QB-1:0]     ch_nre  [QB+1];
   logic [QB-1:0]     ch_nim  [QB+1];
   logic [QB-1:0]     ch_qre  [QB+1];
   logic [QB-1:0]     ch_qim  [QB+1];

   assign ch_ctrl[0] = c_ctrl_ff;
   assign ch_d[0]    = c_d_ff;
   assign ch_rre[0]  = c_rem_re_ff;
   assign ch_rim[0]  = c_rem_im_ff;
   assign ch_nre[0]  = c_nlo_re_ff;
   assign ch_nim[0]  = c_nlo_im_ff;
   assign ch_qre[0]  = '0;
   assign ch_qim[0]  = '0;

   for (genvar i = 0; i < QB; i++) begin : g_cell
      cau_div_cell #(
         .DW   (DW),
         .STEP (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_i   (ch_ctrl[i]),
         .d_i      (ch_d[i]),
         .rem_re_i (ch_rre[i]),
         .rem_im_i (ch_rim[i]),
         .nlo_re_i (ch_nre[i]),
         .nlo_im_i (ch_nim[i]),
         .q_re_i   (ch_qre[i]),
         .q_im_i   (ch_qim[i]),
         .ctrl_o   (ch_ctrl[i+1]),
         .d_o      (ch_d[i+1]),
         .rem_re_o (ch_rre[i+1]),
         .rem_im_o (ch_rim[i+1]),
         .nlo_re_o (ch_nre[i+1]),
         .nlo_im_o (ch_nim[i+1]),
         .q_re_o   (ch_qre[i+1]),
         .q_im_o   (ch_qim[i+1])
      );
   end

   // ---------------- Finish and output register ----------------
   cau_pkg::ctrl_type last;
   logic [16:0]       dsat_re, dsat_im;
   logic [15:0]       out_re_in, out_im_in;
   logic              out_ov_in;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_re_ff, rsp_im_ff;
   logic              rsp_eq_ff, rsp_dz_ff, rsp_ov_ff;

   always_comb begin
      last    = ch_ctrl[QB];
      dsat_re = cau_pkg::sat_mag(last.neg_re, last.qovf_re ? '1 : ch_qre[QB]);
      dsat_im = cau_pkg::sat_mag(last.neg_im, last.qovf_im ? '1 : ch_qim[QB]);
      if (last.is_div) begin
         out_re_in = dsat_re[15:0];
         out_im_in = dsat_im[15:0];
         out_ov_in = dsat_re[16] | dsat_im[16];
      end else begin
         out_re_in = last.res_re;
         out_im_in = last.res_im;
         out_ov_in = last.ov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_re_ff <= out_re_in;
         rsp_im_ff <= out_im_in;
         rsp_eq_ff <= last.eq;
         rsp_dz_ff <= last.dz;
         rsp_ov_ff <= out_ov_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_real    = rsp_re_ff;
   assign rsp_ch.result_imag    = rsp_im_ff;
   assign rsp_ch.is_equal       = rsp_eq_ff;
   assign rsp_ch.divide_by_zero = rsp_dz_ff;
   assign rsp_ch.overflow       = rsp_ov_ff;

endmodule

[rtl/cau_checker.sv]
// Port-level checker for the complex arithmetic unit, bound to the top level.
`include "assert_macros.svh"

module cau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] result_real,
   input logic [15:0] result_imag,
   input logic        is_equal,
   input logic        divide_by_zero,
   input logic        overflow
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(result_real) && $stable(result_imag))
   `ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_valid, !(is_equal && divide_by_zero))
   `ASSERT_IMPL(a_eq_zero_parts, clock, reset, rsp_valid && is_equal, result_real == 16'd0 && result_imag == 16'd0 && !overflow)
   `ASSERT_IMPL(a_dz_zero_parts, clock, reset, rsp_valid && divide_by_zero, result_real == 16'd0 && result_imag == 16'd0 && !overflow)

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .result_real    (rsp_ch.result_real),
   .result_imag    (rsp_ch.result_imag),
   .is_equal       (rsp_ch.is_equal),
   .divide_by_zero (rsp_ch.divide_by_zero),
   .overflow       (rsp_ch.overflow)
);

[bench/tb_complex_arithmetic_unit_top.sv]
// Self-checking bench for the complex arithmetic unit: directed table, then random traffic.
module tb_complex_arithmetic_unit_top;

   // One operand pair as it goes into the block.
   typedef struct {
      logic [2:0]         action;
      logic signed [15:0] ar;
      logic signed [15:0] ai;
      logic signed [15:0] br;
      logic signed [15:0] bi;
   } operand_pair_type;

   // One result as it comes out of the block.
   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               eq;
      logic               dz;
      logic               ov;
   } cplx_result_type;

   // Directed row: the operands plus an optional typed-in result.
   typedef struct {
      operand_pair_type op;
      bit               known;
      cplx_result_type  res;
   } directed_row_type;

   localparam int FRAC         = 8;
   localparam int LATENCY      = 21;
   localparam int RANDOM_ITEMS = 1950;

   logic clock;
   logic reset;

   cau_req_if req_ch();
   cau_rsp_if rsp_ch();

   complex_arithmetic_unit_top #(.FRAC_BITS(FRAC)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   cplx_result_type  pending_results[$];
   directed_row_type directed_rows[$];
   int               mismatches;
   int               send_idle_pct;
   int               recv_stall_pct;
   bit               hold_off;

   // Clock generator: period 12.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Saturate a wide value to 16 signed bits, flagging overflow.
   function automatic logic signed [15:0] clamp16(input longint v, inout logic ov);
      if (v > 32767) begin
         ov = 1'b1;
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         ov = 1'b1;
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   // Drop the fraction bits of a product, rounding half away from zero.
   function automatic longint round_product(input longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      return (v < 0) ? -m : m;
   endfunction

   // Fixed-point quotient num / den, rounded half away from zero.
   function automatic longint round_quotient(input longint num, input longint den);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      m = m <<< FRAC;
      q = (2 * m + den) / (2 * den);
      if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
      return (num < 0) ? -q : q;
   endfunction

   // Compute the result the block must return for one operand pair.
   function automatic cplx_result_type complex_result(input operand_pair_type p);
      cplx_result_type r;
      longint ar, ai, br, bi, den;
      logic ov;
      ar = p.ar; ai = p.ai; br = p.br; bi = p.bi;
      ov = 1'b0;
      r = '0;
      case (p.action)
         cau_pkg::ACT_ADD: begin
            r.re = clamp16(ar + br, ov);
            r.im = clamp16(ai + bi, ov);
         end
         cau_pkg::ACT_SUB: begin
            r.re = clamp16(ar - br, ov);
            r.im = clamp16(ai - bi, ov);
         end
         cau_pkg::ACT_MUL: begin
            r.re = clamp16(round_product(ar * br - ai * bi), ov);
            r.im = clamp16(round_product(ar * bi + ai * br), ov);
         end
         cau_pkg::ACT_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) r.dz = 1'b1;
            else begin
               r.re = clamp16(round_quotient(ar * br + ai * bi, den), ov);
               r.im = clamp16(round_quotient(ai * br - ar * bi, den), ov);
            end
         end
         cau_pkg::ACT_CONJ: begin
            r.re = p.ar;
            r.im = clamp16(-ai, ov);
         end
         cau_pkg::ACT_EQ: r.eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      r.ov = ov;
      return r;
   endfunction

   function automatic logic signed [15:0] random_part();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      p.action = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
      p.ar = random_part();
      p.ai = random_part();
      p.br = random_part();
      p.bi = random_part();
      // Steer equality and zero-divisor cases so they come up often.
      if (p.action == cau_pkg::ACT_EQ && $urandom_range(0, 1) == 1) begin
         p.br = p.ar;
         p.bi = ($urandom_range(0, 3) == 0) ? p.ai ^ 16'h0001 : p.ai;
      end
      if (p.action == cau_pkg::ACT_DIV && $urandom_range(0, 9) == 0) begin
         p.br = '0;
         p.bi = '0;
      end
      return p;
   endfunction

   function automatic operand_pair_type mk(input logic [2:0] act,
                                           input logic signed [15:0] ar, ai, br, bi);
      operand_pair_type p;
      p.action = act; p.ar = ar; p.ai = ai; p.br = br; p.bi = bi;
      return p;
   endfunction

   function automatic cplx_result_type res(input logic signed [15:0] re, im,
                                           input logic eq, dz, ov);
      cplx_result_type r;
      r.re = re; r.im = im; r.eq = eq; r.dz = dz; r.ov = ov;
      return r;
   endfunction

   task automatic add_row(input operand_pair_type p, input bit known = 1'b0,
                          input cplx_result_type r = '0);
      directed_row_type d;
      d.op = p; d.known = known; d.res = r;
      directed_rows.push_back(d);
   endtask

   // Offer one transaction and hold it until the block accepts it.
   task automatic send_pair(input operand_pair_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= p.action;
      req_ch.a_real <= p.ar;
      req_ch.a_imag <= p.ai;
      req_ch.b_real <= p.br;
      req_ch.b_imag <= p.bi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Receiver: stall at random, or hold off entirely during the pressure phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each returned transaction against the oldest expectation.
   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result re=%0d im=%0d",
                                           rsp_ch.result_real, rsp_ch.result_imag);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result_real !== want.re || rsp_ch.result_imag !== want.im ||
                rsp_ch.is_equal !== want.eq || rsp_ch.divide_by_zero !== want.dz ||
                rsp_ch.overflow !== want.ov) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want re=%0d im=%0d eq=%b dz=%b ov=%b, %s",
                           want.re, want.im, want.eq, want.dz, want.ov,
                           $sformatf("got re=%0d im=%0d eq=%b dz=%b ov=%b",
                                     rsp_ch.result_real, rsp_ch.result_imag,
                                     rsp_ch.is_equal, rsp_ch.divide_by_zero,
                                     rsp_ch.overflow));
            end
         end
      end
   end

   // Queue the expectation at the edge where the request is accepted.
   always @(posedge clock) begin
      operand_pair_type p;
      if (!reset && req_ch.valid && req_ch.ready) begin
         p = mk(req_ch.action, req_ch.a_real, req_ch.a_imag, req_ch.b_real, req_ch.b_imag);
         pending_results.push_back(complex_result(p));
      end
   end

   // Hard limit on the run time.
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      operand_pair_type p;
      cplx_result_type  want;
      int k;
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = cau_pkg::ACT_ADD;
      req_ch.a_real = '0;
      req_ch.a_imag = '0;
      req_ch.b_real = '0;
      req_ch.b_imag = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: extremes, each action, and the special cases.
      add_row(mk(cau_pkg::ACT_ADD, 16'sh7FFF, 16'sh7FFF, 16'sd1, 16'sd1), 1'b1,
              res(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b1));
      add_row(mk(cau_pkg::ACT_ADD, -16'sh8000, -16'sh8000, -16'sd1, -16'sd1), 1'b1,
              res(-16'sh8000, -16'sh8000, 1'b0, 1'b0, 1'b1));
      add_row(mk(cau_pkg::ACT_ADD, 16'sd256, -16'sd256, 16'sd512, 16'sd1), 1'b1,
              res(16'sd768, -16'sd255, 1'b0, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_SUB, -16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1), 1'b1,
              res(-16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 1'b1));
      add_row(mk(cau_pkg::ACT_SUB, 16'sd100, 16'sd50, 16'sd30, 16'sd70), 1'b1,
              res(16'sd70, -16'sd20, 1'b0, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0), 1'b1,
              res(16'sd256, 16'sd0, 1'b0, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000));
      add_row(mk(cau_pkg::ACT_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000));
      add_row(mk(cau_pkg::ACT_MUL, 16'sd1, 16'sd0, 16'sd128, 16'sd0));
      add_row(mk(cau_pkg::ACT_MUL, -16'sd1, 16'sd0, 16'sd128, 16'sd0));
      add_row(mk(cau_pkg::ACT_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd0), 1'b1,
              res(16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0));
      add_row(mk(cau_pkg::ACT_DIV, 16'sd512, 16'sd0, 16'sd256, 16'sd0), 1'b1,
              res(16'sd512, 16'sd0, 1'b0, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_DIV, 16'sh7FFF, -16'sh8000, 16'sd1, 16'sd0));
      add_row(mk(cau_pkg::ACT_DIV, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000));
      add_row(mk(cau_pkg::ACT_DIV, 16'sd1, 16'sd1, 16'sh7FFF, 16'sh7FFF));
      add_row(mk(cau_pkg::ACT_CONJ, 16'sd300, -16'sh8000, 16'sd9, 16'sd9), 1'b1,
              res(16'sd300, 16'sh7FFF, 1'b0, 1'b0, 1'b1));
      add_row(mk(cau_pkg::ACT_CONJ, -16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0), 1'b1,
              res(-16'sh8000, -16'sh7FFF, 1'b0, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_EQ, 16'sd42, -16'sd3, 16'sd42, -16'sd3), 1'b1,
              res(16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0));
      add_row(mk(cau_pkg::ACT_EQ, 16'sd42, -16'sd3, 16'sd42, -16'sd4), 1'b1,
              res(16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0));
      add_row(mk(3'd6, 16'sd1, 16'sd2, 16'sd3, 16'sd4), 1'b1,
              res(16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0));
      add_row(mk(3'd7, -16'sd1, -16'sd1, -16'sd1, -16'sd1), 1'b1,
              res(16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0));
      foreach (directed_rows[i]) begin
         // Typed-in rows must also agree with the predictor.
         want = complex_result(directed_rows[i].op);
         if (directed_rows[i].known && want != directed_rows[i].res) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: typed re=%0d im=%0d, predicted re=%0d im=%0d",
                        i, directed_rows[i].res.re, directed_rows[i].res.im,
                        want.re, want.im);
         end
         send_pair(directed_rows[i].op);
      end

      // Random phases: varied idling on either side.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            3: begin send_idle_pct = 18; recv_stall_pct = 18; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (ph == 4) begin
            // Hold the receiver off long enough that the pipe fills and stalls input.
            fork
               begin
                  hold_off = 1'b1;
                  k = 0;
                  while (k < 3 * LATENCY) begin
                     @(posedge clock);
                     k++;
                  end
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            p = random_pair();
            send_pair(p);
         end
      end

      req_ch.valid <= 1'b0;
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_div_cell.sv
rtl/complex_arithmetic_unit_top.sv
rtl/cau_checker.sv
bench/tb_complex_arithmetic_unit_top.sv
